// ===== rtl/plcd_pkg.sv =====
// shared types, codes and helper functions of the pointer-look camera block
package plcd_pkg;

   typedef enum logic [1:0] {
      OP_MOVE  = 2'd0,
      OP_WHEEL = 2'd1,
      OP_LOAD  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_SENSITIVITY = 3'd0,
      REG_PITCH_LIMIT = 3'd1,
      REG_FOV_MIN     = 3'd2,
      REG_FOV_MAX     = 3'd3,
      REG_ZOOM_STEP   = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_ROT,
      ST_CONV,
      ST_PROD,
      ST_OUT
   } state_type;

   // cordic vector, x and y in q2.30, z in 2^32 units per turn
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } rot_type;

   localparam logic [15:0] SENS_RESET  = 16'd4660;
   localparam logic [13:0] LIMIT_RESET = 14'd16201;
   localparam logic [13:0] FMIN_RESET  = 14'd256;
   localparam logic [13:0] FMAX_RESET  = 14'd11520;
   localparam logic [11:0] ZOOM_RESET  = 12'd512;
   localparam logic [13:0] FOV_RESET   = 14'd11520;
   localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

   function automatic logic [31:0] atan_unit(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // round q2.30 (or doubled q2.30 product) to q1.15 and clamp
   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [33:0] t;
      logic signed [15:0] r;
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd32767) r = 16'sd32767;
      else if (t < -34'sd32767) r = -16'sd32767;
      else r = t[15:0];
      return r;
   endfunction

endpackage

// ===== rtl/pointer_look_camera_direction.sv =====
// top level of the pointer-look camera: state update, cordic lanes, result register
// One item at a time: the pointer and wheel products are registered at accept,
// then after a wait state the update state writes yaw, pitch and field of view,
// the item runs through the two cordic cell rows (one for yaw, one for pitch, a
// cell per iteration), the results are rounded to q1.15 and registered, and the
// cos*cos and cos*sin products are formed into the result register. The next
// item is taken in the cycle after the result leaves. Configuration writes are
// always taken (csr_ready is tied high); indexes beyond the list are ignored.
module pointer_look_camera_direction #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_data,
   // input items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [1:0]  req_operation,
   input  logic               req_camera_active,
   input  logic signed [15:0] req_delta_x,
   input  logic signed [15:0] req_delta_y,
   input  logic signed [7:0]  req_wheel_steps,
   input  logic        [15:0] req_load_yaw,
   input  logic signed [14:0] req_load_pitch,
   input  logic        [13:0] req_load_fov,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   output logic        [15:0] rsp_yaw_out,
   output logic signed [14:0] rsp_pitch_out,
   output logic        [13:0] rsp_fov_out,
   output logic               rsp_changed
);

   localparam int CntW = $clog2(CORDIC_STEPS + 1);

   plcd_pkg::state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff;

   // configuration registers
   logic [15:0] sens_ff;
   logic [13:0] limit_ff, fmin_ff, fmax_ff;
   logic [11:0] zoom_ff;

   // camera state
   logic        [15:0] yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic        [13:0] fov_ff, fov_in;

   // captured item
   logic [1:0]         op_ff;
   logic               act_ff;
   logic               nonzero_ff;
   logic [15:0]        lyaw_ff;
   logic signed [14:0] lpitch_ff;
   logic [13:0]        lfov_ff;

   // registered products
   logic signed [33:0] pyaw_ff, ppit_ff;
   logic signed [20:0] pfov_ff;

   // cordic results
   logic signed [15:0] cy, sy, cp, sp;
   logic signed [15:0] cy_ff, sy_ff, cp_ff, sp_ff;

   logic               changed_in;
   logic               changed_ff;
   logic               accept;

   // update datapath
   logic signed [33:0] dyaw, dpit, pcand;
   logic signed [33:0] plim;
   logic signed [22:0] fcand;
   logic        [13:0] fclamp;
   logic signed [14:0] pclamp;
   logic               do_move, do_wheel, do_load;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plcd_pkg::ST_IDLE: if (req_valid) state_in = plcd_pkg::ST_MUL;
         plcd_pkg::ST_MUL:  state_in = plcd_pkg::ST_UPD;
         plcd_pkg::ST_UPD:  state_in = plcd_pkg::ST_ROT;
         plcd_pkg::ST_ROT: begin
            if (cnt_ff == CntW'(CORDIC_STEPS - 1)) state_in = plcd_pkg::ST_CONV;
         end
         plcd_pkg::ST_CONV: state_in = plcd_pkg::ST_PROD;
         plcd_pkg::ST_PROD: state_in = plcd_pkg::ST_OUT;
         plcd_pkg::ST_OUT:  if (!rsp_stall) state_in = plcd_pkg::ST_IDLE;
         default:           state_in = plcd_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         plcd_pkg::ST_IDLE: req_stall = 1'b0;
         plcd_pkg::ST_OUT:  rsp_valid = 1'b1;
         default: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // state update from registered products
   always_comb begin
      do_move  = act_ff && (op_ff == plcd_pkg::OP_MOVE) && nonzero_ff;
      do_wheel = act_ff && (op_ff == plcd_pkg::OP_WHEEL);
      do_load  = act_ff && (op_ff == plcd_pkg::OP_LOAD);

      dyaw = (pyaw_ff + 34'sd128) >>> 8;
      dpit = (ppit_ff + 34'sd128) >>> 8;
      plim = {20'd0, limit_ff};

      // pitch clamp shared by move and load
      if (do_load) pcand = {{19{lpitch_ff[14]}}, lpitch_ff};
      else         pcand = {{19{pitch_ff[14]}}, pitch_ff} + dpit;
      if (pcand < -plim)     pclamp = 15'(-plim);
      else if (pcand > plim) pclamp = 15'(plim);
      else                   pclamp = pcand[14:0];

      // field of view: lower bound first, then upper, so the upper wins
      if (do_load) fcand = {9'd0, lfov_ff};
      else         fcand = {9'd0, fov_ff} - {{2{pfov_ff[20]}}, pfov_ff};
      if (fcand < $signed({9'd0, fmin_ff})) fcand = {9'd0, fmin_ff};
      if (fcand > $signed({9'd0, fmax_ff})) fcand = {9'd0, fmax_ff};
      fclamp = fcand[13:0];

      yaw_in   = yaw_ff;
      pitch_in = pitch_ff;
      fov_in   = fov_ff;
      if (do_move) begin
         yaw_in   = yaw_ff + dyaw[15:0];
         pitch_in = pclamp;
      end else if (do_wheel) begin
         fov_in = fclamp;
      end else if (do_load) begin
         yaw_in   = lyaw_ff;
         pitch_in = pclamp;
         fov_in   = fclamp;
      end
      changed_in = (yaw_in != yaw_ff) || (pitch_in != pitch_ff) || (fov_in != fov_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plcd_pkg::ST_IDLE;
         cnt_ff   <= '0;
         sens_ff  <= plcd_pkg::SENS_RESET;
         limit_ff <= plcd_pkg::LIMIT_RESET;
         fmin_ff  <= plcd_pkg::FMIN_RESET;
         fmax_ff  <= plcd_pkg::FMAX_RESET;
         zoom_ff  <= plcd_pkg::ZOOM_RESET;
         yaw_ff   <= '0;
         pitch_ff <= '0;
         fov_ff   <= plcd_pkg::FOV_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == plcd_pkg::ST_ROT) cnt_ff <= cnt_ff + CntW'(1);
         else                              cnt_ff <= '0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               plcd_pkg::REG_SENSITIVITY: sens_ff  <= csr_data;
               plcd_pkg::REG_PITCH_LIMIT: limit_ff <= csr_data[13:0];
               plcd_pkg::REG_FOV_MIN:     fmin_ff  <= csr_data[13:0];
               plcd_pkg::REG_FOV_MAX:     fmax_ff  <= csr_data[13:0];
               plcd_pkg::REG_ZOOM_STEP:   zoom_ff  <= csr_data[11:0];
               default: ;
            endcase
         end
         if (state_ff == plcd_pkg::ST_UPD) begin
            yaw_ff   <= yaw_in;
            pitch_ff <= pitch_in;
            fov_ff   <= fov_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_operation;
         act_ff     <= req_camera_active;
         nonzero_ff <= (req_delta_x != 16'sd0) || (req_delta_y != 16'sd0);
         lyaw_ff    <= req_load_yaw;
         lpitch_ff  <= req_load_pitch;
         lfov_ff    <= req_load_fov;
         // products registered at accept, ready for the update cycle
         pyaw_ff    <= 34'($signed({req_delta_x[15], req_delta_x})
                        * $signed({1'b0, sens_ff}));
         ppit_ff    <= 34'(-$signed({req_delta_y[15], req_delta_y})
                        * $signed({1'b0, sens_ff}));
         pfov_ff    <= 21'($signed(req_wheel_steps) * $signed({1'b0, zoom_ff}));
      end
      if (state_ff == plcd_pkg::ST_UPD) changed_ff <= changed_in;
      if (state_ff == plcd_pkg::ST_CONV) begin
         cy_ff <= cy;
         sy_ff <= sy;
         cp_ff <= cp;
         sp_ff <= sp;
      end
      if (state_ff == plcd_pkg::ST_PROD) begin
         rsp_dir_x     <= plcd_pkg::to_q15(34'(cp_ff * cy_ff) <<< 1);
         rsp_dir_y     <= sp_ff;
         rsp_dir_z     <= plcd_pkg::to_q15(34'(cp_ff * sy_ff) <<< 1);
         rsp_yaw_out   <= yaw_ff;
         rsp_pitch_out <= pitch_ff;
         rsp_fov_out   <= fov_ff;
         rsp_changed   <= changed_ff;
      end
   end

   // yaw lane
   plcd_lane #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock),
      .angle (yaw_ff),
      .cos_q (cy),
      .sin_q (sy)
   );

   // pitch lane
   plcd_lane #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock),
      .angle ({pitch_ff[14], pitch_ff}),
      .cos_q (cp),
      .sin_q (sp)
   );

endmodule

// ===== rtl/plcd_cell.sv =====
// one cordic rotation cell with its output register
module plcd_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  plcd_pkg::rot_type rot_in,
   output plcd_pkg::rot_type rot_ff
);

   localparam logic signed [31:0] AtanC = signed'(plcd_pkg::atan_unit(STEP));

   plcd_pkg::rot_type rot_in_next;
   logic signed [31:0] dx;
   logic signed [31:0] dy;

   always_comb begin
      dx = rot_in.y >>> STEP;
      dy = rot_in.x >>> STEP;
      if (!rot_in.z[31]) begin
         rot_in_next.x = rot_in.x - dx;
         rot_in_next.y = rot_in.y + dy;
         rot_in_next.z = rot_in.z - AtanC;
      end else begin
         rot_in_next.x = rot_in.x + dx;
         rot_in_next.y = rot_in.y - dy;
         rot_in_next.z = rot_in.z + AtanC;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in_next;
   end

endmodule

// ===== rtl/plcd_lane.sv =====
// row of cordic cells turning one binary angle into q1.15 cosine and sine
module plcd_lane #(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic        [15:0] angle,
   output logic signed [15:0] cos_q,
   output logic signed [15:0] sin_q
);

   plcd_pkg::rot_type stage [0:STEPS];
   plcd_pkg::rot_type seed;
   logic signed [16:0] a_ext;
   logic signed [16:0] a_fold;
   logic               flip;
   logic signed [33:0] vx;
   logic signed [33:0] vy;

   // fold angles beyond a quarter turn into range, negate at the end
   always_comb begin
      a_ext = {angle[15], angle};
      flip  = 1'b0;
      a_fold = a_ext;
      if (a_ext > 17'sd16384) begin
         a_fold = a_ext - 17'sd32768;
         flip   = 1'b1;
      end else if (a_ext < -17'sd16384) begin
         a_fold = a_ext + 17'sd32768;
         flip   = 1'b1;
      end
      seed.x = plcd_pkg::CORDIC_X0;
      seed.y = 32'sd0;
      seed.z = {a_fold[15:0], 16'h0000};
   end

   assign stage[0] = seed;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      plcd_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .rot_in (stage[i]),
         .rot_ff (stage[i+1])
      );
   end

   always_comb begin
      vx = {{2{stage[STEPS].x[31]}}, stage[STEPS].x};
      vy = {{2{stage[STEPS].y[31]}}, stage[STEPS].y};
      if (flip) begin
         vx = -vx;
         vy = -vy;
      end
      cos_q = plcd_pkg::to_q15(vx);
      sin_q = plcd_pkg::to_q15(vy);
   end

endmodule

// ===== verif/plcd_checker.sv =====
// checker for the pointer-look camera: watches the channels, predicts each view result and compares
`timescale 1ns / 100ps

module plcd_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic        [1:0]  req_operation,
   input  logic               req_camera_active,
   input  logic signed [15:0] req_delta_x,
   input  logic signed [15:0] req_delta_y,
   input  logic signed [7:0]  req_wheel_steps,
   input  logic        [15:0] req_load_yaw,
   input  logic signed [14:0] req_load_pitch,
   input  logic        [13:0] req_load_fov,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_dir_x,
   input  logic signed [15:0] rsp_dir_y,
   input  logic signed [15:0] rsp_dir_z,
   input  logic        [15:0] rsp_yaw_out,
   input  logic signed [14:0] rsp_pitch_out,
   input  logic        [13:0] rsp_fov_out,
   input  logic               rsp_changed,
   output int                 fail_count,
   output int                 pending_views,
   output int                 view_count,
   output int                 changed_count
);

   localparam int ROT_STEPS = 16;

   typedef struct {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic        [15:0] yaw;
      logic signed [14:0] pitch;
      logic        [13:0] fov;
      logic               changed;
   } view_type;

   localparam longint ARC_TABLE [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   view_type expected_views[$];

   // mirrored registers and camera state
   logic [15:0] sens;
   logic [13:0] plimit, fmin, fmax;
   logic [11:0] zstep;
   logic [15:0] cam_yaw;
   int          cam_pitch;
   int          cam_fov;

   int fails, seen, n_changed;

   assign fail_count    = fails;
   assign pending_views = expected_views.size();
   assign view_count    = seen;
   assign changed_count = n_changed;

   function automatic longint q15_round(input longint v);
      longint t;
      t = (v + 64'sd16384) >>> 15;
      if (t > 32767) t = 32767;
      if (t < -32767) t = -32767;
      return t;
   endfunction

   task automatic rotate(input logic [15:0] angle, output longint c, output longint s);
      longint a, x, y, z, dx, dy;
      bit     flip;
      a = longint'($signed(angle));
      flip = 0;
      x = 652032874;
      y = 0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1;
      end
      z = a * 65536;
      for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARC_TABLE[i];
         end else begin
            x += dx; y -= dy; z += ARC_TABLE[i];
         end
      end
      c = q15_round(flip ? -x : x);
      s = q15_round(flip ? -y : y);
   endtask

   function automatic int limit_pitch(input longint p);
      if (p < -longint'(plimit)) p = -longint'(plimit);
      if (p > longint'(plimit)) p = longint'(plimit);
      return int'(p);
   endfunction

   function automatic int limit_fov(input longint f);
      if (f < longint'(fmin)) f = longint'(fmin);
      if (f > longint'(fmax)) f = longint'(fmax);
      return int'(f);
   endfunction

   task automatic predict_view(output view_type v);
      logic [15:0] old_yaw;
      int          old_pitch, old_fov;
      longint      dx, dy, cy, sy, cp, sp;
      old_yaw   = cam_yaw;
      old_pitch = cam_pitch;
      old_fov   = cam_fov;
      dx = longint'(req_delta_x);
      dy = longint'(req_delta_y);
      if (req_camera_active) begin
         if (req_operation == plcd_pkg::OP_MOVE && (dx != 0 || dy != 0)) begin
            cam_yaw   = cam_yaw + 16'((dx * longint'(sens) + 128) >>> 8);
            cam_pitch = limit_pitch(longint'(cam_pitch) + ((-dy * longint'(sens) + 128) >>> 8));
         end else if (req_operation == plcd_pkg::OP_WHEEL) begin
            cam_fov = limit_fov(longint'(cam_fov) - longint'(req_wheel_steps) * longint'(zstep));
         end else if (req_operation == plcd_pkg::OP_LOAD) begin
            cam_yaw   = req_load_yaw;
            cam_pitch = limit_pitch(longint'(req_load_pitch));
            cam_fov   = limit_fov(longint'(req_load_fov));
         end
      end
      rotate(cam_yaw, cy, sy);
      rotate(16'(cam_pitch), cp, sp);
      v.dir_x   = 16'(q15_round(cp * cy * 2));
      v.dir_y   = 16'(sp);
      v.dir_z   = 16'(q15_round(cp * sy * 2));
      v.yaw     = cam_yaw;
      v.pitch   = 15'(cam_pitch);
      v.fov     = 14'(cam_fov);
      v.changed = (cam_yaw != old_yaw) || (cam_pitch != old_pitch) || (cam_fov != old_fov);
   endtask

   task automatic compare_view(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         fails++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      view_type v;
      if (reset) begin
         sens      = plcd_pkg::SENS_RESET;
         plimit    = plcd_pkg::LIMIT_RESET;
         fmin      = plcd_pkg::FMIN_RESET;
         fmax      = plcd_pkg::FMAX_RESET;
         zstep     = plcd_pkg::ZOOM_RESET;
         cam_yaw   = '0;
         cam_pitch = 0;
         cam_fov   = int'(plcd_pkg::FOV_RESET);
         expected_views.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               plcd_pkg::REG_SENSITIVITY: sens   = csr_data;
               plcd_pkg::REG_PITCH_LIMIT: plimit = csr_data[13:0];
               plcd_pkg::REG_FOV_MIN:     fmin   = csr_data[13:0];
               plcd_pkg::REG_FOV_MAX:     fmax   = csr_data[13:0];
               plcd_pkg::REG_ZOOM_STEP:   zstep  = csr_data[11:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (expected_views.size() == 0) begin
               fails++;
               $display("%0t unexpected view result, yaw %0d", $time, rsp_yaw_out);
            end else begin
               v = expected_views.pop_front();
               compare_view("dir_x", longint'(v.dir_x), longint'(rsp_dir_x));
               compare_view("dir_y", longint'(v.dir_y), longint'(rsp_dir_y));
               compare_view("dir_z", longint'(v.dir_z), longint'(rsp_dir_z));
               compare_view("yaw", longint'(v.yaw), longint'(rsp_yaw_out));
               compare_view("pitch", longint'(v.pitch), longint'(rsp_pitch_out));
               compare_view("fov", longint'(v.fov), longint'(rsp_fov_out));
               compare_view("changed", longint'(v.changed), longint'(rsp_changed));
               if (rsp_changed) n_changed++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_view(v);
            expected_views.push_back(v);
         end
      end
   end

endmodule

// ===== verif/tb_top.sv =====
// testbench top of the pointer-look camera: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

   localparam int IDLE_LIMIT = 4000;   // cycles with no handshake before giving up
   localparam int DRAIN_WAIT = 40;     // latency margin after the last result

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic        [2:0]  csr_index = '0;
   logic        [15:0] csr_data = '0;
   logic               req_valid = 0;
   logic               req_stall;
   logic        [1:0]  req_operation = '0;
   logic               req_camera_active = 0;
   logic signed [15:0] req_delta_x = '0;
   logic signed [15:0] req_delta_y = '0;
   logic signed [7:0]  req_wheel_steps = '0;
   logic        [15:0] req_load_yaw = '0;
   logic signed [14:0] req_load_pitch = '0;
   logic        [13:0] req_load_fov = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic        [15:0] rsp_yaw_out;
   logic signed [14:0] rsp_pitch_out;
   logic        [13:0] rsp_fov_out;
   logic               rsp_changed;

   int fail_count, pending_views, view_count, changed_count;
   int idle_cycles;
   int items_sent;
   int stall_left;
   bit calm;   // stretches with no idling on either side

   always #10 clock = ~clock;

   pointer_look_camera_direction u_top (.*);

   plcd_checker u_checker (.*);

   // most gaps short, a few long, none while calm
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side stall pattern
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 0;
         stall_left = 0;
         calm = 0;
      end else begin
         if ($urandom_range(0, 299) == 0) calm = ~calm;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = gap_len();
            stall_left = n;
            rsp_stall <= (n > 0);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // watchdog on handshakes of any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("[pointer_look_camera_direction] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one item on the request channel, valid stays high across back-to-back items
   task automatic send_item(input plcd_pkg::op_type op, input logic act,
                            input logic [15:0] dx,
                            input logic [15:0] dy, input logic [7:0] wh,
                            input logic [15:0] ly, input logic [14:0] lp,
                            input logic [13:0] lf);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1;
      req_operation     <= op;
      req_camera_active <= act;
      req_delta_x       <= dx;
      req_delta_y       <= dy;
      req_wheel_steps   <= wh;
      req_load_yaw      <= ly;
      req_load_pitch    <= lp;
      req_load_fov      <= lf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // lower valid and let every expected view arrive, then the latency margin
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_views != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input plcd_pkg::reg_index_type idx, input logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [15:0] s, input logic [15:0] pl, input logic [15:0] fmn,
                            input logic [15:0] fmx, input logic [15:0] zs);
      write_reg(plcd_pkg::REG_SENSITIVITY, s);
      write_reg(plcd_pkg::REG_PITCH_LIMIT, pl);
      write_reg(plcd_pkg::REG_FOV_MIN, fmn);
      write_reg(plcd_pkg::REG_FOV_MAX, fmx);
      write_reg(plcd_pkg::REG_ZOOM_STEP, zs);
   endtask

   // random deltas: mostly modest motion, sometimes full range
   function automatic logic [15:0] rand_delta();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return '0;
         default: return 16'($signed($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   task automatic send_random();
      plcd_pkg::op_type op;
      int     r;
      logic   act;
      r = $urandom_range(0, 99);
      if (r < 55) op = plcd_pkg::OP_MOVE;
      else if (r < 78) op = plcd_pkg::OP_WHEEL;
      else if (r < 96) op = plcd_pkg::OP_LOAD;
      else op = plcd_pkg::op_type'(2'd3);   // unused code
      act = ($urandom_range(0, 9) != 0);
      send_item(op, act, rand_delta(), rand_delta(),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($signed($urandom_range(0, 8)) - 4),
                16'($urandom), 15'($urandom), 14'($urandom));
   endtask

   task automatic random_burst(input int n);
      repeat (n) send_random();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes and every special case, reset settings
      send_item(plcd_pkg::OP_MOVE, 1, 16'sd0, 16'sd0, 8'sd0, 16'd0, 15'sd0, 14'd0);  // zero move
      send_item(plcd_pkg::OP_MOVE, 1, 16'sd1, 16'sd0, 8'sd0, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_MOVE, 1, 16'sh7fff, 16'sh8000, 8'sd0, 16'd0, 15'sd0,
                14'd0);                                                    // pitch clamps high
      send_item(plcd_pkg::OP_MOVE, 1, 16'sh8000, 16'sh7fff, 8'sd0, 16'd0, 15'sd0,
                14'd0);                                                    // pitch clamps low
      send_item(plcd_pkg::OP_MOVE, 1, 16'shffff, 16'shffff, 8'sh7f, 16'hffff, 15'sh3fff,
                14'h3fff);
      send_item(plcd_pkg::OP_MOVE, 0, 16'sd500, 16'sd500, 8'sd0, 16'd0, 15'sd0,
                14'd0);                                                    // no camera
      send_item(plcd_pkg::OP_WHEEL, 1, 16'sd0, 16'sd0, 8'sh7f, 16'd0, 15'sd0, 14'd0); // fov min
      send_item(plcd_pkg::OP_WHEEL, 1, 16'sd0, 16'sd0, 8'sh80, 16'd0, 15'sd0, 14'd0); // fov max
      send_item(plcd_pkg::OP_WHEEL, 1, 16'sd0, 16'sd0, 8'sd1, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_WHEEL, 0, 16'sd0, 16'sd0, 8'sd3, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'hffff, 15'sh3fff, 14'h3fff);
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'h0000, 15'sh4000, 14'h0000);
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'h8000, 15'sd0,
                14'd5000);                                                 // half turn
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'h4000, 15'sd8000, 14'd5000);
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'hc000, -15'sd8000, 14'd5000);
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'h4001, 15'sd16201, 14'd5000);
      send_item(plcd_pkg::op_type'(2'd3), 1, 16'sd9, 16'sd9, 8'sd2, 16'h1234, 15'sd77, 14'd99);
      send_item(plcd_pkg::OP_LOAD, 0, 16'sd0, 16'sd0, 8'sd0, 16'h1111, 15'sd1, 14'd1);
      drain();   // sender holds off until every view is back

      // pitch outside a lowered limit stays until a move or load clamps it
      write_all(16'hffff, 16'd100, 16'd8000, 16'd2000, 16'hfff);   // inverted fov bounds
      send_item(plcd_pkg::OP_WHEEL, 1, 16'sd0, 16'sd0, 8'sd1, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_WHEEL, 1, 16'sd0, 16'sd0, 8'sh80, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_MOVE, 1, 16'sd1, 16'sd0, 8'sd0, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_MOVE, 1, 16'sh7fff, 16'sh8000, 8'sd0, 16'd0, 15'sd0, 14'd0);
      send_item(plcd_pkg::OP_LOAD, 1, 16'sd0, 16'sd0, 8'sd0, 16'h0, 15'sh4000, 14'h3fff);
      random_burst(120);
      drain();

      // other extreme: zero sensitivity, widest limits, no zoom
      write_all(16'd0, 16'h3fff, 16'd0, 16'h3fff, 16'd0);
      random_burst(100);
      drain();

      // back to reset values
      write_all(plcd_pkg::SENS_RESET, 16'(plcd_pkg::LIMIT_RESET), 16'(plcd_pkg::FMIN_RESET),
                16'(plcd_pkg::FMAX_RESET), 16'(plcd_pkg::ZOOM_RESET));
      random_burst(150);
      drain();

      // a few random settings, fov bounds sometimes inverted
      repeat (4) begin
         write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         random_burst(60);
         drain();
      end

      $display("sent %0d items, checked %0d views (%0d with a change)", items_sent,
               view_count, changed_count);
      $display("settings: reset, both register extremes, inverted fov bounds, 4 random");
      if (fail_count == 0 && pending_views == 0)
         $display("[pointer_look_camera_direction] OK");
      else
         $display("[pointer_look_camera_direction] ERROR");
      $finish;
   end

endmodule
